// ===== hdl/rtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotozoom texture mapper package
// Shared constants, opcodes, register indexes, word types and the frame start
// calculation used by the front end, the back end and the checker.
// ----------------------------------------------------------------------------
package rtm_pkg;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int STEP_W    = 16;
    localparam int IDX_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int ACC_W     = 32;

    // Screen geometry
    localparam int SCR_W = 320;
    localparam int SCR_H = 200;
    localparam int COL_W = 9;
    localparam int ROW_W = 8;

    // Parameter defaults
    localparam int DEF_TEX_W     = 320;
    localparam int DEF_TEX_H     = 200;
    localparam int DEF_FRAC_BITS = 10;

    // Queue depths (powers of two)
    localparam int MIDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 8;

    // Opcodes
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_PIXEL   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COL_STEP_U = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_STEP_V = 1'b1;

    // Register reset values
    localparam logic signed [STEP_W-1:0] STEP_U_RESET = 16'sd1024;
    localparam logic signed [STEP_W-1:0] STEP_V_RESET = 16'sd0;

    typedef struct packed {
        logic [ACC_W-1:0] u;
        logic [ACC_W-1:0] v;
    } t_start;

    // Word passed from the front end to the back end
    typedef struct packed {
        logic              is_pix;
        logic [ACC_W-1:0]  acc_u;
        logic [ACC_W-1:0]  acc_v;
        logic [ADDR_W-1:0] texel_address;
        logic [DATA_W-1:0] texel_value;
        logic [IDX_W-1:0]  screen_index;
        logic              end_of_row;
        logic              end_of_frame;
    } t_entry;

    // Result word
    typedef struct packed {
        logic [DATA_W-1:0] pixel_value;
        logic [IDX_W-1:0]  screen_index;
        logic              end_of_row;
        logic              end_of_frame;
    } t_result;

    // Top-left texture position so that the screen centre maps to (160, 100).
    function automatic t_start frame_start(input logic signed [STEP_W-1:0] cu,
                                           input logic signed [STEP_W-1:0] cv,
                                           input int                       frac);
        logic signed [ACC_W-1:0] su;
        logic signed [ACC_W-1:0] sv;
        t_start                  s;
        su  = ACC_W'(cu);
        sv  = ACC_W'(cv);
        s.u = ACC_W'(-(su * (SCR_W / 2)) + sv * (SCR_H / 2) + ((SCR_W / 2) << frac));
        s.v = ACC_W'(-(sv * (SCR_W / 2)) - su * (SCR_H / 2) + ((SCR_H / 2) << frac));
        return s;
    endfunction

endpackage

// ===== hdl/rotozoom_texture_mapper.sv =====
// ----------------------------------------------------------------------------
// Rotozoom texture mapper
// Walks a tiled byte texture along a rotated, scaled grid and emits one
// texel per screen pixel of a 320 x 200 raster.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------------
//   input     push / full          i_opcode, i_texel_address, i_texel_value
//   result    empty / pop          o_pixel_value, o_screen_index,
//                                  o_end_of_row, o_end_of_frame
//   config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One word is taken per clock while full is low; a pixel request passes
// through the middle queue, the wrap pipeline, the address register and the
// texture read to the result side, and one result per clock can be drained.
// The single-port texture memory sets the rate: one write or one read per cycle.
// Reset is synchronous and active low; it clears the queues, the walk and the
// step registers, but not the texture, which holds rubbish until written.
// If pop is held low the result queue fills, the back end stops taking words,
// the middle queue fills and full rises; words already taken are never lost.
//
// Structure: the front end decodes words and owns the accumulators; a short
// queue decouples it from the back end, which wraps the coordinates in a
// three-stage multiply-by-reciprocal pipeline, forms the texture address,
// accesses the texture memory and pushes results into the output queue.
// The back end reserves a result slot for each pixel it issues, so its
// pipeline never has to stall.
// ----------------------------------------------------------------------------
module rotozoom_texture_mapper #(
    parameter int TEX_W     = rtm_pkg::DEF_TEX_W,
    parameter int TEX_H     = rtm_pkg::DEF_TEX_H,
    parameter int FRAC_BITS = rtm_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input word
    input  logic                          push,
    output logic                          full,
    input  logic [rtm_pkg::OP_W-1:0]      i_opcode,
    input  logic [rtm_pkg::ADDR_W-1:0]    i_texel_address,
    input  logic [rtm_pkg::DATA_W-1:0]    i_texel_value,
    // Result word
    output logic                          empty,
    input  logic                          pop,
    output logic [rtm_pkg::DATA_W-1:0]    o_pixel_value,
    output logic [rtm_pkg::IDX_W-1:0]     o_screen_index,
    output logic                          o_end_of_row,
    output logic                          o_end_of_frame,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic [rtm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rtm_pkg::STEP_W-1:0]    i_cfg_data
);

    localparam int ENT_W = $bits(rtm_pkg::t_entry);

    logic             accept;
    logic             f_push;
    rtm_pkg::t_entry  f_entry;
    logic [ENT_W-1:0] mq_data;
    logic             mq_empty;
    logic             b_take;
    rtm_pkg::t_result res;

    // A word is accepted whenever the middle queue has room.
    assign accept = push && !full;

    rtm_front #(
        .TEX_W     (TEX_W),
        .TEX_H     (TEX_H),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_opcode        (i_opcode),
        .i_texel_address (i_texel_address),
        .i_texel_value   (i_texel_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_push          (f_push),
        .o_entry         (f_entry)
    );

    // Middle queue between the front and back ends. Restarts and unused
    // opcodes never enter it; they act on the front end alone.
    rtm_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (rtm_pkg::MIDQ_DEPTH)
    ) u_midq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_entry),
        .i_pop   (b_take),
        .o_data  (mq_data),
        .o_full  (full),
        .o_empty (mq_empty)
    );

    rtm_back #(
        .TEX_W     (TEX_W),
        .TEX_H     (TEX_H),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!mq_empty),
        .i_head  (rtm_pkg::t_entry'(mq_data)),
        .o_take  (b_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res)
    );

    assign o_pixel_value  = res.pixel_value;
    assign o_screen_index = res.screen_index;
    assign o_end_of_row   = res.end_of_row;
    assign o_end_of_frame = res.end_of_frame;

endmodule

// ===== hdl/rtm_fifo.sv =====
// ----------------------------------------------------------------------------
// Rotozoom small register queue
// First-word-fall-through queue of flat words, power-of-two depth.
// ----------------------------------------------------------------------------
module rtm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

// ===== hdl/rtm_front.sv =====
// ----------------------------------------------------------------------------
// Rotozoom front end
// Holds the step registers and the walk accumulators, decodes each accepted
// word and hands texel writes and pixel requests to the back end.
// ----------------------------------------------------------------------------
module rtm_front #(
    parameter int TEX_W     = rtm_pkg::DEF_TEX_W,
    parameter int TEX_H     = rtm_pkg::DEF_TEX_H,
    parameter int FRAC_BITS = rtm_pkg::DEF_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [rtm_pkg::OP_W-1:0]        i_opcode,
    input  logic [rtm_pkg::ADDR_W-1:0]      i_texel_address,
    input  logic [rtm_pkg::DATA_W-1:0]      i_texel_value,
    input  logic                            i_cfg_we,
    input  logic [rtm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rtm_pkg::STEP_W-1:0]      i_cfg_data,
    output logic                            o_push,
    output rtm_pkg::t_entry                 o_entry
);

    localparam int TEX_SIZE = TEX_W * TEX_H;

    logic signed [rtm_pkg::STEP_W-1:0] r_step_u;
    logic signed [rtm_pkg::STEP_W-1:0] r_step_v;
    logic [rtm_pkg::ACC_W-1:0]         r_row_u;
    logic [rtm_pkg::ACC_W-1:0]         r_row_v;
    logic [rtm_pkg::ACC_W-1:0]         r_pix_u;
    logic [rtm_pkg::ACC_W-1:0]         r_pix_v;
    logic [rtm_pkg::COL_W-1:0]         r_col;
    logic [rtm_pkg::ROW_W-1:0]         r_row;
    logic [rtm_pkg::IDX_W-1:0]         r_scr;

    rtm_pkg::t_start           n_start;
    rtm_pkg::t_start           rst_start;
    logic [rtm_pkg::ACC_W-1:0] step_u;
    logic [rtm_pkg::ACC_W-1:0] step_v;
    logic                      eor;
    logic                      eof;
    logic                      addr_ok;

    assign n_start   = rtm_pkg::frame_start(r_step_u, r_step_v, FRAC_BITS);
    assign rst_start = rtm_pkg::frame_start(rtm_pkg::STEP_U_RESET, rtm_pkg::STEP_V_RESET,
                                            FRAC_BITS);
    assign step_u    = rtm_pkg::ACC_W'(r_step_u);
    assign step_v    = rtm_pkg::ACC_W'(r_step_v);
    assign eor       = (r_col == rtm_pkg::COL_W'(rtm_pkg::SCR_W - 1));
    assign eof       = eor && (r_row == rtm_pkg::ROW_W'(rtm_pkg::SCR_H - 1));
    assign addr_ok   = (32'(i_texel_address) < 32'(TEX_SIZE));

    always_comb begin
        o_entry.is_pix        = (i_opcode == rtm_pkg::OP_PIXEL);
        o_entry.acc_u         = r_pix_u;
        o_entry.acc_v         = r_pix_v;
        o_entry.texel_address = i_texel_address;
        o_entry.texel_value   = i_texel_value;
        o_entry.screen_index  = r_scr;
        o_entry.end_of_row    = eor;
        o_entry.end_of_frame  = eof;
        o_push = i_accept && ((i_opcode == rtm_pkg::OP_PIXEL) ||
                              ((i_opcode == rtm_pkg::OP_WRITE) && addr_ok));
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_u <= rtm_pkg::STEP_U_RESET;
            r_step_v <= rtm_pkg::STEP_V_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rtm_pkg::REG_COL_STEP_U: r_step_u <= i_cfg_data;
                rtm_pkg::REG_COL_STEP_V: r_step_v <= i_cfg_data;
            endcase
        end
    end

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_u <= rst_start.u;
            r_row_v <= rst_start.v;
            r_pix_u <= rst_start.u;
            r_pix_v <= rst_start.v;
            r_col   <= '0;
            r_row   <= '0;
            r_scr   <= '0;
        end else if (i_accept) begin
            unique case (i_opcode)
                rtm_pkg::OP_WRITE, rtm_pkg::OP_NONE: begin
                end
                rtm_pkg::OP_RESTART: begin
                    r_row_u <= n_start.u;
                    r_row_v <= n_start.v;
                    r_pix_u <= n_start.u;
                    r_pix_v <= n_start.v;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_scr   <= '0;
                end
                rtm_pkg::OP_PIXEL: begin
                    if (eof) begin
                        r_row_u <= n_start.u;
                        r_row_v <= n_start.v;
                        r_pix_u <= n_start.u;
                        r_pix_v <= n_start.v;
                        r_col   <= '0;
                        r_row   <= '0;
                        r_scr   <= '0;
                    end else if (eor) begin
                        r_row_u <= r_row_u - step_v;
                        r_row_v <= r_row_v + step_u;
                        r_pix_u <= r_row_u - step_v;
                        r_pix_v <= r_row_v + step_u;
                        r_col   <= '0;
                        r_row   <= r_row + 1'b1;
                        r_scr   <= r_scr + 1'b1;
                    end else begin
                        r_pix_u <= r_pix_u + step_u;
                        r_pix_v <= r_pix_v + step_v;
                        r_col   <= r_col + 1'b1;
                        r_scr   <= r_scr + 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// ===== hdl/rtm_wrap.sv =====
// ----------------------------------------------------------------------------
// Rotozoom coordinate wrap
// Three-stage pipeline: floor of a fixed-point accumulator, reduced modulo a
// constant texture size to a nonnegative coordinate.
// ----------------------------------------------------------------------------
module rtm_wrap #(
    parameter int M         = rtm_pkg::DEF_TEX_W,
    parameter int FRAC_BITS = rtm_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic [rtm_pkg::ACC_W-1:0]   i_acc,
    output logic [$clog2(M)-1:0]        o_coord
);

    // The floored value is offset by half the integer range so it is never
    // negative; the offset is taken back out after the reduction.
    localparam int          W  = rtm_pkg::ACC_W - FRAC_BITS;
    localparam int          CW = $clog2(M);
    localparam longint      R  = (64'(1) << W) / M;
    localparam longint      K  = (64'(1) << (W - 1)) % M;

    logic [W-1:0]   r_t1;
    logic [2*W-1:0] r_p;
    logic [W-1:0]   r_t2;
    logic [W-1:0]   r_qm;
    logic [CW-1:0]  r_c;

    logic [W-1:0]   t;
    logic [W-1:0]   q;
    logic [CW:0]    d;
    logic [CW:0]    rr;
    logic [CW:0]    n_c;

    assign t = {~i_acc[rtm_pkg::ACC_W-1], i_acc[rtm_pkg::ACC_W-2:FRAC_BITS]};
    assign q = r_p[2*W-1:W];

    always_comb begin
        d  = (CW + 1)'(r_t2 - r_qm);
        rr = (d >= (CW + 1)'(M)) ? d - (CW + 1)'(M) : d;
        if (rr >= (CW + 1)'(K)) begin
            n_c = rr - (CW + 1)'(K);
        end else begin
            n_c = rr + (CW + 1)'(M - K);
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1    <= t;
        r_p     <= (2 * W)'(t) * (2 * W)'(R);
        r_t2    <= r_t1;
        r_qm    <= W'((2 * W)'(q) * (2 * W)'(M));
        r_c     <= CW'(n_c);
    end

    assign o_coord = r_c;

endmodule

// ===== hdl/rtm_back.sv =====
// ----------------------------------------------------------------------------
// Rotozoom back end
// Wraps the walk coordinates, forms the texture address, performs texel writes
// and reads on the texture memory and queues the results.
// ----------------------------------------------------------------------------
module rtm_back #(
    parameter int TEX_W     = rtm_pkg::DEF_TEX_W,
    parameter int TEX_H     = rtm_pkg::DEF_TEX_H,
    parameter int FRAC_BITS = rtm_pkg::DEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  rtm_pkg::t_entry  i_head,
    output logic             o_take,
    input  logic             i_pop,
    output logic             o_empty,
    output rtm_pkg::t_result o_res
);

    localparam int DEPTH  = TEX_W * TEX_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int UW     = $clog2(TEX_W);
    localparam int VW     = $clog2(TEX_H);
    localparam int PEND_W = $clog2(rtm_pkg::OUTQ_DEPTH + 1);
    localparam int RES_W  = $bits(rtm_pkg::t_result);

    typedef struct packed {
        logic                       is_pix;
        logic [rtm_pkg::ADDR_W-1:0] texel_address;
        logic [rtm_pkg::DATA_W-1:0] texel_value;
        logic [rtm_pkg::IDX_W-1:0]  screen_index;
        logic                       end_of_row;
        logic                       end_of_frame;
    } t_tag;

    logic [rtm_pkg::DATA_W-1:0] r_mem [DEPTH];

    logic [3:0]                 r_vld;
    t_tag                       r_tag [4];
    logic [AW-1:0]              r_addr;
    logic                       r_out_vld;
    t_tag                       r_out_tag;
    logic [rtm_pkg::DATA_W-1:0] r_rd;
    logic [PEND_W-1:0]          r_pend;

    logic                       issue;
    logic                       issue_pix;
    logic                       out_pop;
    logic [UW-1:0]              tx;
    logic [VW-1:0]              ty;
    t_tag                       head_tag;
    rtm_pkg::t_result           push_res;
    logic [RES_W-1:0]           q_data;

    // Result slots are reserved at issue, so the result queue never overflows
    // and the pipeline needs no stall.
    assign issue     = i_avail &&
                       (!i_head.is_pix || (r_pend < PEND_W'(rtm_pkg::OUTQ_DEPTH)));
    assign issue_pix = issue && i_head.is_pix;
    assign o_take    = issue;
    assign out_pop   = i_pop && !o_empty;

    always_comb begin
        head_tag.is_pix        = i_head.is_pix;
        head_tag.texel_address = i_head.texel_address;
        head_tag.texel_value   = i_head.texel_value;
        head_tag.screen_index  = i_head.screen_index;
        head_tag.end_of_row    = i_head.end_of_row;
        head_tag.end_of_frame  = i_head.end_of_frame;
    end

    rtm_wrap #(
        .M         (TEX_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_wrap_u (
        .i_clk   (i_clk),
        .i_acc   (i_head.acc_u),
        .o_coord (tx)
    );

    rtm_wrap #(
        .M         (TEX_H),
        .FRAC_BITS (FRAC_BITS)
    ) u_wrap_v (
        .i_clk   (i_clk),
        .i_acc   (i_head.acc_v),
        .o_coord (ty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= '0;
        end else begin
            r_vld     <= {r_vld[2:0], issue};
            r_out_vld <= r_vld[3] && r_tag[3].is_pix;
            r_pend    <= r_pend + PEND_W'(issue_pix) - PEND_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0]  <= head_tag;
        r_tag[1]  <= r_tag[0];
        r_tag[2]  <= r_tag[1];
        r_tag[3]  <= r_tag[2];
        r_out_tag <= r_tag[3];
        if (r_tag[2].is_pix) begin
            r_addr <= AW'(AW'(ty) * AW'(TEX_W)) + AW'(tx);
        end else begin
            r_addr <= AW'(r_tag[2].texel_address);
        end
    end

    // Texture memory: one port, written by texel writes, read by pixels
    always_ff @(posedge i_clk) begin
        if (r_vld[3] && !r_tag[3].is_pix) begin
            r_mem[r_addr] <= r_tag[3].texel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
    end

    always_comb begin
        push_res.pixel_value  = r_rd;
        push_res.screen_index = r_out_tag.screen_index;
        push_res.end_of_row   = r_out_tag.end_of_row;
        push_res.end_of_frame = r_out_tag.end_of_frame;
    end

    rtm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (rtm_pkg::OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_out_vld),
        .i_data  (push_res),
        .i_pop   (i_pop),
        .o_data  (q_data),
        .o_full  (),
        .o_empty (o_empty)
    );

    assign o_res = rtm_pkg::t_result'(q_data);

endmodule

// ===== hdl/rtm_checker.sv =====
// ----------------------------------------------------------------------------
// Rotozoom port checker
// Watches the top-level ports for queue behaviour and frame marker sanity.
// ----------------------------------------------------------------------------
module rtm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [rtm_pkg::DATA_W-1:0]    o_pixel_value,
    input  logic [rtm_pkg::IDX_W-1:0]     o_screen_index,
    input  logic                          o_end_of_row,
    input  logic                          o_end_of_frame
);

    // After reset both queues are empty.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A frame can only close on the close of a row.
    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_frame) |-> o_end_of_row)
        else $error("end of frame without end of row");

    // The last pixel of a frame sits at the last screen position.
    a_eof_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_frame) |->
        (o_screen_index == rtm_pkg::IDX_W'(rtm_pkg::SCR_W * rtm_pkg::SCR_H - 1)))
        else $error("end of frame at wrong screen index");

    // A result that is not taken stays put.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
        (!empty && $stable(o_screen_index) && $stable(o_pixel_value)))
        else $error("waiting result changed");

endmodule

bind rotozoom_texture_mapper rtm_checker u_rtm_checker (.*);
